@@ src/blr_pkg.sv @@
`default_nettype none

package blr_pkg;

  localparam int COORD_BITS = 12;
  localparam int SPAN_BITS  = COORD_BITS + 1;
  localparam int ERR_BITS   = COORD_BITS + 4;
  localparam int COLOR_BITS = 16;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [SPAN_BITS-1:0]  delta_t;
  typedef logic        [SPAN_BITS-1:0]  span_t;
  typedef logic signed [ERR_BITS-1:0]   err_t;
  typedef logic        [COLOR_BITS-1:0] color_t;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_STEP  = 1'b1
  } func_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
    logic   last_pixel;
  } pix_t;

  // sign-extend a coordinate to the difference width
  function automatic delta_t coord_ext(coord_t c);
    return delta_t'(c);
  endfunction

  // twice a span, zero-extended into the error width
  function automatic err_t span_x2(span_t s);
    return err_t'({s, 1'b0});
  endfunction

endpackage

`default_nettype wire

@@ src/blr_if.sv @@
`default_nettype none

interface blr_in_if;
  import blr_pkg::*;

  logic   valid;
  logic   ready;
  func_t  func;
  coord_t x_start;
  coord_t y_start;
  coord_t x_end;
  coord_t y_end;

  modport source (output valid, func, x_start, y_start, x_end, y_end, input ready);
  modport sink   (input valid, func, x_start, y_start, x_end, y_end, output ready);
endinterface

interface blr_out_if;
  import blr_pkg::*;

  logic   valid;
  logic   ready;
  coord_t pixel_x;
  coord_t pixel_y;
  color_t pixel_color;
  logic   last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

interface blr_cfg_if;
  import blr_pkg::*;

  logic   valid;
  logic   ready;
  color_t data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

@@ src/bresenham_line_rasterizer.sv @@
`default_nettype none

// Bresenham line rasterizer. A start word (func = 0) loads two endpoints and
// produces nothing; the endpoints are ordered so that y never decreases (a
// flat line runs from x_end to x_start). Each step word (func = 1) then emits
// one pixel in the current line_color, with last_pixel set on the final one;
// a step with no line loaded is consumed and produces nothing. A start word
// at any time drops the old line. The step update is one add and one sign
// test on the error term, between the line-state and output registers, so
// a new word is taken every clock while in_word.ready is high. The output
// side has a main register plus a skid slot that fills while the main one
// is held, so in_word.ready depends only on local state and falls only when
// both hold pixels not yet taken. line_color is written via cfg_word (always
// ready) only while no line work is in flight: the user's rule, unenforced.
module bresenham_line_rasterizer (
  input  logic      clk,
  input  logic      rst_n,
  blr_in_if.sink    in_word,
  blr_out_if.source out_word,
  blr_cfg_if.sink   cfg_word
);
  import blr_pkg::*;

  // line state
  color_t line_color_r;
  coord_t cur_x_r, cur_x_nxt;
  coord_t cur_y_r, cur_y_nxt;
  err_t   err_r, err_nxt;
  span_t  left_r, left_nxt;
  span_t  span_x_r, span_x_nxt;
  span_t  span_y_r, span_y_nxt;
  logic   x_fwd_r, x_fwd_nxt;
  logic   x_major_r, x_major_nxt;
  logic   active_r, active_nxt;

  // output register and skid slot
  pix_t   out_pix_r, skid_pix_r;
  logic   out_valid_r, skid_valid_r;

  logic   in_acc, push, pop;
  pix_t   new_pix;

  // start-word decode
  logic   swap;
  coord_t x0, y0, x1, y1;
  delta_t dx, dy;
  logic   fwd_s;
  span_t  sx_s, sy_s;
  logic   maj_s;

  // step-word update
  logic   e_pos;
  err_t   min2, maj2;

  assign in_word.ready = !skid_valid_r;
  assign in_acc        = in_word.valid && in_word.ready;
  assign push          = in_acc && (in_word.func == FUNC_STEP) && active_r;
  assign pop           = out_valid_r && out_word.ready;

  assign cfg_word.ready = 1'b1;

  // endpoint ordering and spans
  always_comb begin
    swap  = (in_word.y_end <= in_word.y_start);
    x0    = swap ? in_word.x_end   : in_word.x_start;
    y0    = swap ? in_word.y_end   : in_word.y_start;
    x1    = swap ? in_word.x_start : in_word.x_end;
    y1    = swap ? in_word.y_start : in_word.y_end;
    dx    = coord_ext(x1) - coord_ext(x0);
    dy    = coord_ext(y1) - coord_ext(y0);
    fwd_s = !dx[SPAN_BITS-1];
    sx_s  = fwd_s ? span_t'(dx) : span_t'(-dx);
    sy_s  = span_t'(dy);
    maj_s = (sy_s <= sx_s);
  end

  // current pixel as it leaves
  always_comb begin
    new_pix.pixel_x     = cur_x_r;
    new_pix.pixel_y     = cur_y_r;
    new_pix.pixel_color = line_color_r;
    new_pix.last_pixel  = (left_r <= span_t'(1));
  end

  always_comb begin
    e_pos = !err_r[ERR_BITS-1];
    min2  = x_major_r ? span_x2(span_y_r) : span_x2(span_x_r);
    maj2  = x_major_r ? span_x2(span_x_r) : span_x2(span_y_r);

    cur_x_nxt   = cur_x_r;
    cur_y_nxt   = cur_y_r;
    err_nxt     = err_r;
    left_nxt    = left_r;
    span_x_nxt  = span_x_r;
    span_y_nxt  = span_y_r;
    x_fwd_nxt   = x_fwd_r;
    x_major_nxt = x_major_r;
    active_nxt  = active_r;

    if (in_acc && (in_word.func == FUNC_START)) begin
      cur_x_nxt   = x0;
      cur_y_nxt   = y0;
      span_x_nxt  = sx_s;
      span_y_nxt  = sy_s;
      x_fwd_nxt   = fwd_s;
      x_major_nxt = maj_s;
      active_nxt  = 1'b1;
      if (maj_s) begin
        err_nxt  = span_x2(sy_s) - err_t'(sx_s);
        left_nxt = sx_s + span_t'(1);
      end else begin
        err_nxt  = span_x2(sx_s) - err_t'(sy_s);
        left_nxt = sy_s + span_t'(1);
      end
    end else if (push) begin
      // major axis always advances; minor only when error is non-negative
      err_nxt = e_pos ? (err_r + min2 - maj2) : (err_r + min2);
      if (x_major_r || e_pos) begin
        cur_x_nxt = x_fwd_r ? (cur_x_r + coord_t'(1)) : (cur_x_r - coord_t'(1));
      end
      if (!x_major_r || e_pos) begin
        cur_y_nxt = cur_y_r + coord_t'(1);
      end
      if (left_r <= span_t'(1)) begin
        left_nxt   = '0;
        active_nxt = 1'b0;
      end else begin
        left_nxt = left_r - span_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_color_r <= '0;
      cur_x_r      <= '0;
      cur_y_r      <= '0;
      err_r        <= '0;
      left_r       <= '0;
      span_x_r     <= '0;
      span_y_r     <= '0;
      x_fwd_r      <= 1'b1;
      x_major_r    <= 1'b0;
      active_r     <= 1'b0;
    end else begin
      if (cfg_word.valid && cfg_word.ready) begin
        line_color_r <= cfg_word.data;
      end
      cur_x_r   <= cur_x_nxt;
      cur_y_r   <= cur_y_nxt;
      err_r     <= err_nxt;
      left_r    <= left_nxt;
      span_x_r  <= span_x_nxt;
      span_y_r  <= span_y_nxt;
      x_fwd_r   <= x_fwd_nxt;
      x_major_r <= x_major_nxt;
      active_r  <= active_nxt;
    end
  end

  // output register with skid slot; push never happens while skid is full
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_pix_r <= skid_pix_r;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_pix_r <= new_pix;
      end else begin
        skid_pix_r <= new_pix;
      end
    end
  end

  assign out_word.valid       = out_valid_r;
  assign out_word.pixel_x     = out_pix_r.pixel_x;
  assign out_word.pixel_y     = out_pix_r.pixel_y;
  assign out_word.pixel_color = out_pix_r.pixel_color;
  assign out_word.last_pixel  = out_pix_r.last_pixel;

  // skid slot only fills behind a held output word
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot valid while output register empty");

  // the cycle after a step on an active line, the output register is valid
  a_step_emits: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_valid_r)
    else $error("step on active line produced no pixel");

  // the last pixel ends the line
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    push && new_pix.last_pixel |=> !active_r)
    else $error("line still active after its last pixel");

  // an active line always has pixels left
  a_active_left: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (left_r != '0))
    else $error("active line with no pixels left");

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps

// Line rasterizer bench. Start words load endpoints, step words pull pixels.
// A behavioral line walker runs beside the block: every accepted word is fed
// to it, and each pixel it would emit is queued. The pixel monitor pops the
// oldest queued pixel per output handshake and compares field by field.
// Both the word sender and the pixel sink insert random gaps of idle clocks,
// switched off for some stretches so the block also runs back to back.
module tb;
  import blr_pkg::*;

  localparam int MAX_GAP    = 6;
  localparam int SETTLE_CYC = 8;    // covers a start or swallowed step still in flight
  localparam int RAND_WORDS = 750;
  localparam int SHORT_REACH = 12;  // most random lines stay a few pixels long
  localparam int MID_REACH   = 200;

  logic clk = 1'b0;
  logic rst_n;

  blr_in_if  in_if();
  blr_out_if out_if();
  blr_cfg_if cfg_if();

  bresenham_line_rasterizer dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_word (in_if),
    .out_word(out_if),
    .cfg_word(cfg_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // line walker state, kept in plain ints; coordinates wrap to coord_t on output
  color_t line_color_m;
  int     pen_x, pen_y;
  int     err_acc;
  int     pixels_left;
  int     run_x, run_y;
  bit     x_fwd, x_maj, drawing;

  pix_t   pix_expect[$];   // pixels owed by the block, oldest first
  int     mismatches;
  int     words_sent;      // words that did something (ignored steps not counted)
  bit     no_idle;         // when set, neither side inserts gaps

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 100)
      $display("%0t MISMATCH: %s", $time, msg);
  endtask

  // Walk one accepted word. A start reorders the endpoints so y never
  // decreases (flat lines get swapped too) and sets up the error term; a step
  // emits the pen position, then advances it (minor axis too if err >= 0).
  function automatic void rasterize_word(func_t f, coord_t xs, coord_t ys,
                                         coord_t xe, coord_t ye);
    int   x0, y0, x1, y1, dx, dy, t;
    pix_t px;
    if (f == FUNC_START) begin
      x0 = xs; y0 = ys; x1 = xe; y1 = ye;
      if (y1 - y0 <= 0) begin
        t = x0; x0 = x1; x1 = t;
        t = y0; y0 = y1; y1 = t;
      end
      dx = x1 - x0;
      dy = y1 - y0;
      x_fwd = (dx >= 0);
      run_x = x_fwd ? dx : -dx;
      run_y = dy;
      x_maj = (run_y <= run_x);
      if (x_maj) begin
        err_acc     = 2 * run_y - run_x;
        pixels_left = run_x + 1;
      end else begin
        err_acc     = 2 * run_x - run_y;
        pixels_left = run_y + 1;
      end
      pen_x   = x0;
      pen_y   = y0;
      drawing = 1'b1;
    end else if (drawing) begin
      px.pixel_x     = coord_t'(pen_x);
      px.pixel_y     = coord_t'(pen_y);
      px.pixel_color = line_color_m;
      px.last_pixel  = (pixels_left <= 1);
      pix_expect.push_back(px);
      // minor-axis move when the error term is non-negative
      if (err_acc >= 0) begin
        if (x_maj) begin
          err_acc += 2 * run_y - 2 * run_x;
          pen_y   += 1;
        end else begin
          err_acc += 2 * run_x - 2 * run_y;
          pen_x   += x_fwd ? 1 : -1;
        end
      end else begin
        err_acc += x_maj ? 2 * run_y : 2 * run_x;
      end
      if (x_maj) pen_x += x_fwd ? 1 : -1;
      else       pen_y += 1;
      if (pixels_left <= 1) begin
        pixels_left = 0;
        drawing     = 1'b0;
      end else begin
        pixels_left--;
      end
    end
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(0, 7))
      0:       return -2048;
      1:       return 2047;
      default: return int'($urandom_range(0, 4095)) - 2048;
    endcase
  endfunction

  // a coordinate within reach of c, folded back if it would leave the range
  function automatic int near_coord(int c, int reach);
    int d;
    d = int'($urandom_range(0, 2 * reach)) - reach;
    if (c + d > 2047 || c + d < -2048) d = -d;
    return c + d;
  endfunction

  // One word through the input channel. valid stays high when the next word
  // follows with no gap; callers that stop sending go through wait_idle.
  task automatic send_word(func_t f, coord_t xs, coord_t ys, coord_t xe, coord_t ye);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.func    <= f;
    in_if.x_start <= xs;
    in_if.y_start <= ys;
    in_if.x_end   <= xe;
    in_if.y_end   <= ye;
    do @(posedge clk); while (!in_if.ready);
    if (f == FUNC_START || drawing) words_sent++;
    rasterize_word(f, xs, ys, xe, ye);
  endtask

  // endpoint fields are don't-care on a step; fill them with noise
  task automatic send_step();
    send_word(FUNC_STEP, coord_t'(rand_coord()), coord_t'(rand_coord()),
              coord_t'(rand_coord()), coord_t'(rand_coord()));
  endtask

  task automatic send_line(int xs, int ys, int xe, int ye, int n_steps);
    send_word(FUNC_START, coord_t'(xs), coord_t'(ys), coord_t'(xe), coord_t'(ye));
    repeat (n_steps) send_step();
  endtask

  // Hold off until every owed pixel has arrived, then let any start or
  // swallowed step still in the pipe settle.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pix_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_color(color_t c);
    wait_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= c;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    line_color_m = c;
  endtask

  // Steps right after reset find no line and must produce nothing.
  task automatic test_idle_steps();
    send_step();
    send_step();
    wait_idle();
  endtask

  // Hand-picked lines: one pixel, flat, vertical, and the corners of the
  // coordinate range, several cut short by the next start.
  task automatic test_directed_lines();
    write_color(16'hFFFF);
    send_line(5, 5, 5, 5, 2);              // one pixel; second step finds no line
    send_line(-3, 7, 2, 7, 3);             // flat: runs from x_end toward x_start
    send_line(0, -2048, 0, -2045, 4);      // vertical, walked to its last pixel
    write_color(16'h0000);
    send_line(-2048, -2048, 2047, 2047, 2);
    send_line(2047, 2047, -2048, -2048, 2);  // swapped to climb
    send_line(-2048, 2047, 2047, -2048, 1);
    send_line(2047, -2048, -2048, 2047, 1);
    wait_idle();
  endtask

  // Mostly short lines walked to the end, mixed with lines dropped midway,
  // wild endpoints, stray steps and idle points with a new color.
  task automatic test_random_lines();
    int     base, kind, steps, phase;
    int     x0, y0, x1, y1, ax, ay;
    color_t c;
    base  = words_sent;
    phase = 0;
    while (words_sent - base < RAND_WORDS) begin
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
        x0 = rand_coord();
        y0 = rand_coord();
        x1 = near_coord(x0, SHORT_REACH);
        y1 = near_coord(y0, SHORT_REACH);
        ax = (x1 > x0) ? x1 - x0 : x0 - x1;
        ay = (y1 > y0) ? y1 - y0 : y0 - y1;
        steps = ((ax > ay) ? ax : ay) + 1;
        // now and then run past the end: those steps are swallowed
        if ($urandom_range(0, 3) == 0) steps += $urandom_range(1, 2);
        send_line(x0, y0, x1, y1, steps);
      end else if (kind < 17) begin
        x0 = rand_coord();
        y0 = rand_coord();
        send_line(x0, y0, near_coord(x0, MID_REACH), near_coord(y0, MID_REACH),
                  $urandom_range(0, 10));
      end else if (kind == 17) begin
        send_line(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  $urandom_range(0, 8));
      end else if (kind == 18) begin
        repeat ($urandom_range(1, 3)) send_step();
      end else begin
        // idle point: sender stalls until all pixels are back, then recolor
        case ($urandom_range(0, 3))
          0:       c = 16'h0000;
          1:       c = 16'hFFFF;
          default: c = color_t'($urandom_range(0, 65535));
        endcase
        write_color(c);
        no_idle = (phase % 4 == 2) || ($urandom_range(0, 5) == 0);
        phase++;
      end
    end
    no_idle = 1'b0;
    wait_idle();
  endtask

  // Pixel sink: a fresh random stall before each word, ready held until taken.
  initial begin : pixel_sink
    int gap;
    out_if.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  // Pixel monitor: values sampled at the edge, before the block updates them.
  always @(posedge clk) begin : pixel_check
    pix_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pix_expect.size() == 0) begin
        report_mismatch($sformatf("pixel (%0d,%0d) with none owed",
                                  out_if.pixel_x, out_if.pixel_y));
      end else begin
        want = pix_expect.pop_front();
        if (out_if.pixel_x !== want.pixel_x)
          report_mismatch($sformatf("pixel_x got %0d expected %0d",
                                    out_if.pixel_x, want.pixel_x));
        if (out_if.pixel_y !== want.pixel_y)
          report_mismatch($sformatf("pixel_y got %0d expected %0d",
                                    out_if.pixel_y, want.pixel_y));
        if (out_if.pixel_color !== want.pixel_color)
          report_mismatch($sformatf("pixel_color got %h expected %h",
                                    out_if.pixel_color, want.pixel_color));
        if (out_if.last_pixel !== want.last_pixel)
          report_mismatch($sformatf("last_pixel got %b expected %b at (%0d,%0d)",
                                    out_if.last_pixel, want.last_pixel,
                                    want.pixel_x, want.pixel_y));
      end
    end
  end

  initial begin : run_tests
    in_if.valid   <= 1'b0;
    in_if.func    <= FUNC_START;
    in_if.x_start <= '0;
    in_if.y_start <= '0;
    in_if.x_end   <= '0;
    in_if.y_end   <= '0;
    cfg_if.valid  <= 1'b0;
    cfg_if.data   <= '0;
    rst_n         <= 1'b0;

    mismatches   = 0;
    words_sent   = 0;
    no_idle      = 1'b0;
    line_color_m = '0;
    pen_x        = 0;
    pen_y        = 0;
    err_acc      = 0;
    pixels_left  = 0;
    run_x        = 0;
    run_y        = 0;
    x_fwd        = 1'b1;
    x_maj        = 1'b0;
    drawing      = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_steps();
    test_directed_lines();
    test_random_lines();

    wait_idle();
    if (mismatches == 0)
      $display("bresenham_line_rasterizer test passed");
    else
      $display("bresenham_line_rasterizer test failed");
    $finish;
  end

  // hang guard: far beyond the slowest legal run
  initial begin : watchdog
    #1_000_000;
    $display("bresenham_line_rasterizer test failed");
    $finish;
  end

endmodule
